### hw/rtl/gvgh_pkg.sv
// Package for the Gaussian value/gradient/Hessian core.
// Holds the transaction structs, register indexes, exp constants and saturation helpers.
// No dependencies.
package gvgh_pkg;

   // Input transaction: displacement from centre to point, Q16.16
   typedef struct packed {
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [31:0] disp_z;
      logic               row_end;
   } gvgh_req_type;

   // Result transaction: value Q1.30, derivatives Q16.16
   typedef struct packed {
      logic        [30:0] value;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
      logic signed [31:0] hess_xx;
      logic signed [31:0] hess_xy;
      logic signed [31:0] hess_xz;
      logic signed [31:0] hess_yy;
      logic signed [31:0] hess_yz;
      logic signed [31:0] hess_zz;
      logic               row_end_out;
   } gvgh_rsp_type;

   // Register map
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPONENT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIMENSIONS = 1'b1;

   localparam logic [23:0] EXPONENT_RESET   = 24'd65536;
   localparam logic [1:0]  DIMENSIONS_RESET = 2'd3;
   localparam logic [1:0]  DIM_2D           = 2'd2;

   // exp constants
   localparam logic [31:0] LOG2E_Q31 = 32'd3098164010;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   // 2^(-i/4) in Q1.30
   localparam logic [30:0] POW2_QUARTER [0:3] = '{
      31'd1073741824, 31'd902905651, 31'd759250125, 31'd638450708
   };

   // Exact floor(v/j) for v < 2^30: (v * RECIP[j]) >> SHIFT[j]
   localparam logic [31:0] HORNER_RECIP [1:6] = '{
      32'd1073741824, 32'd1073741824, 32'd1431655766,
      32'd1073741824, 32'd1717986919, 32'd1431655766
   };
   localparam logic [5:0] HORNER_SHIFT [1:6] = '{
      6'd30, 6'd31, 6'd32, 6'd32, 6'd33, 6'd33
   };

   // Apply sign to a magnitude and clamp to the signed 32-bit range
   function automatic logic [31:0] encode_sat(input logic [40:0] mag, input logic neg);
      logic [31:0] lim;
      if (neg) begin
         lim = (mag > 41'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
         return 32'd0 - lim;
      end
      return (mag > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   // floor(m / 2^48), anything at or above 2^32 reported as 2^32
   function automatic logic [40:0] hess_mag(input logic [111:0] m);
      return (|m[111:80]) ? 41'h1_0000_0000 : {9'd0, m[79:48]};
   endfunction

endpackage

### hw/rtl/gaussian_value_gradient_hessian_core.sv
// Top level of the Gaussian value/gradient/Hessian core: 28-stage pipeline.
// Depends on gvgh_pkg.
//
// Usage:
//  - req_*: one transaction per displacement (x, y, z in Q16.16, row_end tag).
//    Taken at a clock edge with req_valid high and req_stall low.
//  - rsp_*: one transaction per request, in order: value exp(-c*r2) in Q1.30,
//    gradient and symmetric Hessian in Q16.16, saturated, row_end copied.
//  - csr_*: write-only registers (exponent c in Q8.16, dimensions 2 or 3).
//    Write only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_stall is low, set by the
// fully pipelined datapath (every multiplier has its own stage, the exp
// Horner steps are unrolled).
// Stall: a stalled result holds in the output register; earlier stages keep
// advancing into empty slots, so req_stall rises only once every stage is
// full. Nothing is dropped or repeated.
// Reset: synchronous, clears all stage valid bits and loads exponent 1.0
// and 3-D mode. There is no clearing pass.
module gaussian_value_gradient_hessian_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gvgh_pkg::gvgh_req_type                req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gvgh_pkg::gvgh_rsp_type                rsp_payload,
   input  logic                                  csr_wr_en,
   input  logic [gvgh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gvgh_pkg::CSR_DATA_W-1:0]       csr_data
);
   import gvgh_pkg::*;

   localparam int NSTAGE = 28;
   localparam int ST_HORNER = 9;
   // operand pairing of the six Hessian products: three diagonal, xy, xz, yz
   localparam int PROD_G [0:5] = '{0, 1, 2, 1, 2, 2};
   localparam int PROD_W [0:5] = '{0, 1, 2, 0, 0, 1};

   // side data carried down the pipeline
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             row_end;
      logic             zero;
      logic [4:0]       k;
      logic [1:0]       idx;
      logic [29:0]      x;
      logic [30:0]      p;
      logic [54:0]      cp;
      logic [2:0][55:0] g;
      logic [2:0][55:0] w;
   } side_type;

   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // configuration registers
   logic [23:0] exp_ff;
   logic [1:0]  dim_ff;
   logic        two_d;

   // pipeline control
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] ld;

   side_type side_ff [0:NSTAGE-2];
   side_type side_in [0:NSTAGE-2];

   // datapath registers
   logic [63:0]  sq_ff [0:2];
   logic [63:0]  r2_ff;
   logic [55:0]  hp_ff, crl_ff;
   logic [36:0]  t_ff;
   logic [36:0]  th_ff;
   logic [63:0]  tl_ff;
   logic [29:0]  frac_ff;
   logic [61:0]  xp_ff;
   logic [61:0]  qm6_ff;
   logic [62:0]  prod_ff [0:4];
   logic [61:0]  qm_ff [0:4];
   logic [63:0]  mm_ff;
   logic [62:0]  pl_ff [0:2];
   logic [54:0]  ph_ff [0:2];
   logic [63:0]  ll_ff [0:5];
   logic [55:0]  lh_ff [0:5];
   logic [55:0]  hl_ff [0:5];
   logic [47:0]  hh_ff [0:5];
   logic [111:0] a_ff [0:5];
   logic [111:0] dmag_ff [0:2];
   logic [2:0]   dneg_ff;
   logic [111:0] offa_ff [0:2];
   gvgh_rsp_type rsp_ff;

   // combinational intermediates
   logic [31:0]  disp [0:2];
   logic [2:0]   in_neg;
   logic [2:0][31:0] in_mag;
   logic [40:0]  tsum;
   logic [38:0]  u;
   logic [29:0]  x8;
   logic [61:0]  hsrc [0:4];
   logic [61:0]  hq [0:4];
   logic [32:0]  hs [0:4];
   logic [61:0]  hqf;
   logic [32:0]  s0;
   logic [30:0]  m20;
   logic [30:0]  p20;
   logic [55:0]  gmul [0:2];
   logic [2:0][55:0] g21;
   logic [54:0]  cp21;
   logic [86:0]  wsum [0:2];
   logic [2:0][55:0] w23;
   logic [111:0] asum [0:5];
   logic [111:0] cbig;
   logic [2:0]   ge;
   logic [111:0] dm [0:2];
   gvgh_rsp_type rsp_in;

   assign two_d = (dim_ff == DIM_2D);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= EXPONENT_RESET;
         dim_ff <= DIMENSIONS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_EXPONENT:   exp_ff <= csr_data;
            REG_DIMENSIONS: dim_ff <= csr_data[1:0];
         endcase
      end
   end

   // a stage loads unless it and every stage after it are full and the output stalls
   for (genvar i = 0; i < NSTAGE; i++) begin : g_ld
      assign ld[i] = !(rsp_stall && (&vld_ff[NSTAGE-1:i]));
   end

   assign req_stall   = !ld[0];
   assign rsp_valid   = vld_ff[NSTAGE-1];
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[0]) vld_ff[0] <= req_valid;
         for (int i = 1; i < NSTAGE; i++) begin
            if (ld[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // arithmetic between stages
   always_comb begin
      // input: drop z in 2-D, split sign and magnitude
      disp[0] = req_payload.disp_x;
      disp[1] = req_payload.disp_y;
      disp[2] = two_d ? 32'd0 : req_payload.disp_z;
      for (int a = 0; a < 3; a++) begin
         in_neg[a] = disp[a][31];
         in_mag[a] = in_neg[a] ? (~disp[a] + 32'd1) : disp[a];
      end

      // t = c*r2 in Q5.32
      tsum = {4'd0, hp_ff[20:0], 16'd0} + {1'b0, crl_ff[55:16]};
      // u = t*log2(e)
      u = {1'b0, th_ff, 1'b0} + {6'd0, tl_ff[63:31]};
      x8 = xp_ff[61:32];

      // Horner steps for e^-x, divisor 6 down to 1
      hsrc[0] = qm6_ff;
      for (int h = 1; h < 5; h++) hsrc[h] = qm_ff[h-1];
      for (int h = 0; h < 5; h++) begin
         hq[h] = hsrc[h] >> HORNER_SHIFT[6-h];
         hs[h] = ONE_Q32 - {3'd0, hq[h][29:0]};
      end
      hqf = qm_ff[4] >> HORNER_SHIFT[1];
      s0  = ONE_Q32 - {3'd0, hqf[29:0]};

      // value after the integer shift
      m20 = mm_ff[62:32];
      p20 = side_ff[19].zero ? 31'd0 : (m20 >> side_ff[19].k);

      // log-gradient magnitudes and c*p
      for (int a = 0; a < 3; a++) begin
         gmul[a] = 56'(exp_ff) * 56'(side_ff[20].mag[a]);
         g21[a]  = {gmul[a][54:0], 1'b0};
      end
      cp21 = 55'(exp_ff) * 55'(side_ff[20].p);

      // W = floor(G*p / 2^30)
      for (int a = 0; a < 3; a++) begin
         wsum[a] = {ph_ff[a], 32'd0} + 87'(pl_ff[a]);
         w23[a]  = wsum[a][85:30];
      end

      // recombine partial products
      for (int n = 0; n < 6; n++) begin
         asum[n] = 112'(ll_ff[n]) + {24'd0, lh_ff[n], 32'd0} + {24'd0, hl_ff[n], 32'd0}
                 + {hh_ff[n], 64'd0};
      end

      // diagonal: |G*W - 2c*p*2^18|
      cbig = {38'd0, side_ff[25].cp, 19'd0};
      for (int n = 0; n < 3; n++) begin
         ge[n] = (a_ff[n] >= cbig);
         dm[n] = ge[n] ? (a_ff[n] - cbig) : (cbig - a_ff[n]);
      end

      // output formatting
      rsp_in.value   = side_ff[26].p;
      rsp_in.grad_x  = encode_sat({1'b0, side_ff[26].w[0][55:16]}, !side_ff[26].neg[0]);
      rsp_in.grad_y  = encode_sat({1'b0, side_ff[26].w[1][55:16]}, !side_ff[26].neg[1]);
      rsp_in.grad_z  = two_d ? 32'd0 :
                       encode_sat({1'b0, side_ff[26].w[2][55:16]}, !side_ff[26].neg[2]);
      rsp_in.hess_xx = encode_sat(hess_mag(dmag_ff[0]), dneg_ff[0]);
      rsp_in.hess_yy = encode_sat(hess_mag(dmag_ff[1]), dneg_ff[1]);
      rsp_in.hess_zz = two_d ? 32'd0 : encode_sat(hess_mag(dmag_ff[2]), dneg_ff[2]);
      rsp_in.hess_xy = encode_sat(hess_mag(offa_ff[0]),
                                  side_ff[26].neg[0] ^ side_ff[26].neg[1]);
      rsp_in.hess_xz = two_d ? 32'd0 : encode_sat(hess_mag(offa_ff[1]),
                                  side_ff[26].neg[0] ^ side_ff[26].neg[2]);
      rsp_in.hess_yz = two_d ? 32'd0 : encode_sat(hess_mag(offa_ff[2]),
                                  side_ff[26].neg[1] ^ side_ff[26].neg[2]);
      rsp_in.row_end_out = side_ff[26].row_end;
   end

   // side data: copy forward, overwrite where a stage produces a field
   always_comb begin
      side_in[0]         = '0;
      side_in[0].mag     = in_mag;
      side_in[0].neg     = in_neg;
      side_in[0].row_end = req_payload.row_end;
      for (int i = 1; i < NSTAGE-1; i++) side_in[i] = side_ff[i-1];
      side_in[4].zero  = (|hp_ff[55:21]) || (|tsum[40:37]);
      side_in[6].zero  = side_ff[5].zero || (u[38:32] >= 7'd31);
      side_in[6].k     = u[36:32];
      side_in[6].idx   = u[31:30];
      side_in[8].x     = x8;
      side_in[20].p    = p20;
      side_in[21].g    = g21;
      side_in[21].cp   = cp21;
      side_in[23].w    = w23;
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE-1; i++) begin
         if (ld[i]) side_ff[i] <= side_in[i];
      end
      // squared distance
      if (ld[1]) begin
         for (int a = 0; a < 3; a++)
            sq_ff[a] <= 64'(side_ff[0].mag[a]) * 64'(side_ff[0].mag[a]);
      end
      if (ld[2]) r2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      // c*r2 halves
      if (ld[3]) begin
         hp_ff  <= 56'(exp_ff) * 56'(r2_ff[63:32]);
         crl_ff <= 56'(exp_ff) * 56'(r2_ff[31:0]);
      end
      if (ld[4]) t_ff <= tsum[36:0];
      if (ld[5]) begin
         th_ff <= 37'(t_ff[36:32]) * 37'(LOG2E_Q31);
         tl_ff <= 64'(t_ff[31:0]) * 64'(LOG2E_Q31);
      end
      if (ld[6]) frac_ff <= u[29:0];
      if (ld[7]) xp_ff <= 62'(frac_ff) * 62'(LN2_Q32);
      if (ld[8]) qm6_ff <= 62'(x8) * 62'(HORNER_RECIP[6]);
      // Horner: product stage then reciprocal stage per step
      for (int h = 0; h < 5; h++) begin
         if (ld[ST_HORNER + 2*h])
            prod_ff[h] <= 63'(side_ff[ST_HORNER - 1 + 2*h].x) * 63'(hs[h]);
         if (ld[ST_HORNER + 1 + 2*h])
            qm_ff[h] <= 62'(prod_ff[h][61:32]) * 62'(HORNER_RECIP[5-h]);
      end
      if (ld[19]) mm_ff <= 64'(POW2_QUARTER[side_ff[18].idx]) * 64'(s0);
      // G*p partial products
      if (ld[22]) begin
         for (int a = 0; a < 3; a++) begin
            pl_ff[a] <= 63'(side_ff[21].g[a][31:0]) * 63'(side_ff[21].p);
            ph_ff[a] <= 55'(side_ff[21].g[a][55:32]) * 55'(side_ff[21].p);
         end
      end
      // G*W partial products
      if (ld[24]) begin
         for (int n = 0; n < 6; n++) begin
            ll_ff[n] <= 64'(side_ff[23].g[PROD_G[n]][31:0])
                      * 64'(side_ff[23].w[PROD_W[n]][31:0]);
            lh_ff[n] <= 56'(side_ff[23].g[PROD_G[n]][31:0])
                      * 56'(side_ff[23].w[PROD_W[n]][55:32]);
            hl_ff[n] <= 56'(side_ff[23].g[PROD_G[n]][55:32])
                      * 56'(side_ff[23].w[PROD_W[n]][31:0]);
            hh_ff[n] <= 48'(side_ff[23].g[PROD_G[n]][55:32])
                      * 48'(side_ff[23].w[PROD_W[n]][55:32]);
         end
      end
      if (ld[25]) begin
         for (int n = 0; n < 6; n++) a_ff[n] <= asum[n];
      end
      if (ld[26]) begin
         for (int n = 0; n < 3; n++) begin
            dmag_ff[n] <= dm[n];
            dneg_ff[n] <= !ge[n];
            offa_ff[n] <= a_ff[3+n];
         end
      end
      if (ld[27]) rsp_ff <= rsp_in;
   end

   // checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while output register empty");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.value <= 31'h4000_0000))
      else $error("value above one");

   a_zero_value_zero_grad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.value == 31'd0)) |->
      (rsp_payload.grad_x == 32'sd0) && (rsp_payload.grad_y == 32'sd0) &&
      (rsp_payload.grad_z == 32'sd0) && (rsp_payload.hess_xy == 32'sd0))
      else $error("non-zero derivative with zero value");

endmodule
